// ===== sv/adic_pkg.sv =====
// Shared types and constants for the ASCII decimal to integer converter.
package adic_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic [2:0] target_kind;
  } in_beat_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOT_INT = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [32:0] value;
    status_e            status;
  } out_beat_t;

  typedef enum logic [2:0] {
    KIND_RAW = 3'd0,
    KIND_U8  = 3'd1,
    KIND_S8  = 3'd2,
    KIND_U16 = 3'd3,
    KIND_S16 = 3'd4,
    KIND_U32 = 3'd5,
    KIND_S32 = 3'd6
  } kind_e;

  typedef struct packed {
    logic [31:0] magnitude;
    logic        in_token;
    logic        is_negative;
    logic        saw_digit;
    logic        bad_syntax;
    logic        over_range;
  } tok_state_t;

  localparam logic [31:0] NegLimit = 32'd2147483648;
  localparam logic [31:0] PosLimit = 32'd4294967295;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic signed [33:0] ValZero = 34'sd0;
  localparam logic signed [33:0] U8Max   = 34'sd255;
  localparam logic signed [33:0] S8Min   = -34'sd128;
  localparam logic signed [33:0] S8Max   = 34'sd127;
  localparam logic signed [33:0] U16Max  = 34'sd65535;
  localparam logic signed [33:0] S16Min  = -34'sd32768;
  localparam logic signed [33:0] S16Max  = 34'sd32767;
  localparam logic signed [33:0] S32Max  = 34'sd2147483647;

endpackage

// ===== sv/adic_in_stage.sv =====
// Input register stage that holds one accepted character beat.
module adic_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  adic_pkg::in_beat_t in_data_i,
  input  logic             consume_i,
  output logic             held_valid_o,
  output adic_pkg::in_beat_t held_data_o
);

  logic               valid_q;
  adic_pkg::in_beat_t data_q;
  logic               load;

  // The stage refills in the same cycle the held beat moves on.
  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_data_o  = data_q;

endmodule

// ===== sv/adic_step.sv =====
// Per-character token update and end-of-token result evaluation.
module adic_step (
  input  adic_pkg::tok_state_t state_i,
  input  adic_pkg::in_beat_t   beat_i,
  output adic_pkg::tok_state_t state_o,
  output logic                 emit_o,
  output adic_pkg::out_beat_t  result_o
);

  logic [7:0]         c;
  logic               blank;
  logic               ender;
  logic               is_digit;
  logic               is_sign;
  logic               do_char;
  logic [35:0]        scaled;
  logic [35:0]        limit;
  logic signed [33:0] vmag;
  logic signed [33:0] v;
  logic               fits;

  assign c        = beat_i.char_code;
  assign blank    = (c == adic_pkg::CharSpace) || (c == adic_pkg::CharTab);
  assign ender    = blank || (c == adic_pkg::CharNul) || (c == adic_pkg::CharCr) ||
                    (c == adic_pkg::CharLf);
  assign is_digit = (c >= adic_pkg::CharZero) && (c <= adic_pkg::CharNine);
  assign is_sign  = (c == adic_pkg::CharPlus) || (c == adic_pkg::CharMinus);

  // Multiply by ten as two shifts and an add; ASCII digits carry their value in the low nibble.
  assign scaled = ({4'b0, state_i.magnitude} << 3) + ({4'b0, state_i.magnitude} << 1) +
                  {32'b0, c[3:0]};
  assign limit  = {4'b0, (state_i.is_negative ? adic_pkg::NegLimit : adic_pkg::PosLimit)};

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    do_char = 1'b0;
    if (!state_i.in_token) begin
      if (blank) begin
        emit_o = 1'b0;
      end else if (ender) begin
        emit_o  = 1'b1;
        state_o = '0;
      end else begin
        state_o.in_token = 1'b1;
        if (is_sign) begin
          state_o.is_negative = (c == adic_pkg::CharMinus);
        end else begin
          do_char = 1'b1;
        end
      end
    end else if (ender) begin
      emit_o  = 1'b1;
      state_o = '0;
    end else begin
      do_char = 1'b1;
    end

    if (do_char) begin
      if (is_digit) begin
        state_o.saw_digit = 1'b1;
        if (!state_i.bad_syntax && !state_i.over_range) begin
          if (scaled > limit) begin
            state_o.over_range = 1'b1;
            state_o.magnitude  = limit[31:0];
          end else begin
            state_o.magnitude  = scaled[31:0];
          end
        end
      end else begin
        state_o.bad_syntax = 1'b1;
      end
    end
  end

  assign vmag = {2'b00, state_i.magnitude};
  assign v    = state_i.is_negative ? -vmag : vmag;

  always_comb begin
    case (adic_pkg::kind_e'(beat_i.target_kind))
      adic_pkg::KIND_U8:  fits = (v >= adic_pkg::ValZero) && (v <= adic_pkg::U8Max);
      adic_pkg::KIND_S8:  fits = (v >= adic_pkg::S8Min) && (v <= adic_pkg::S8Max);
      adic_pkg::KIND_U16: fits = (v >= adic_pkg::ValZero) && (v <= adic_pkg::U16Max);
      adic_pkg::KIND_S16: fits = (v >= adic_pkg::S16Min) && (v <= adic_pkg::S16Max);
      adic_pkg::KIND_U32: fits = (v >= adic_pkg::ValZero);
      adic_pkg::KIND_S32: fits = (v <= adic_pkg::S32Max);
      default:            fits = 1'b1;
    endcase
  end

  always_comb begin
    result_o.value = '0;
    if (state_i.bad_syntax || !state_i.saw_digit) begin
      result_o.status = adic_pkg::STATUS_NOT_INT;
    end else if (state_i.over_range) begin
      result_o.status = adic_pkg::STATUS_RANGE;
    end else if (fits) begin
      result_o.status = adic_pkg::STATUS_OK;
      result_o.value  = v[32:0];
    end else begin
      result_o.status = adic_pkg::STATUS_RANGE;
    end
  end

endmodule

// ===== sv/ascii_decimal_to_int_checked.sv =====
// Top level of the streaming ASCII decimal to integer converter with range checks.
//
//   Channel  Direction  Handshake              Beat type
//   in       input      in_valid_i/in_ready_o  adic_pkg::in_beat_t (char_code, target_kind)
//   out      output     out_valid_o/out_ready_i adic_pkg::out_beat_t (value, status)
//
// One beat per cycle unless a token end stalls; the single token-update stage sets it.
// A result is loaded into the output register when its ending character is taken.
// Reset clears the token state and both valid flags; no clearing pass is needed.
// A stalled result holds only beats that end a token; other characters keep flowing.
module ascii_decimal_to_int_checked (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adic_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adic_pkg::out_beat_t out_data_o
);

  logic                 held_valid;
  adic_pkg::in_beat_t   held_data;
  logic                 step_fire;
  adic_pkg::tok_state_t tok_q;
  adic_pkg::tok_state_t tok_d;
  logic                 emit;
  adic_pkg::out_beat_t  result;
  logic                 out_valid_q;
  adic_pkg::out_beat_t  out_q;

  adic_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .consume_i    (step_fire),
    .held_valid_o (held_valid),
    .held_data_o  (held_data)
  );

  adic_step u_step (
    .state_i  (tok_q),
    .beat_i   (held_data),
    .state_o  (tok_d),
    .emit_o   (emit),
    .result_o (result)
  );

  // A beat that ends a token needs a free output slot; any other beat goes straight through.
  assign step_fire = held_valid && (!emit || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (step_fire) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != adic_pkg::STATUS_OK)) |-> (out_data_o.value == '0))
    else $error("error result carries a nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q.is_negative |-> (tok_q.magnitude <= adic_pkg::NegLimit))
    else $error("negative magnitude passed its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && emit) |=> (tok_q == '0))
    else $error("token state not cleared after a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && emit && out_valid_q && !out_ready_i) |-> !step_fire)
    else $error("result overwrote a stalled output beat");
`endif

endmodule
